@@ rtl/wsfhp_pkg.sv @@
package wsfhp_pkg;

  // default width of the buffer size field
  localparam int SIZE_WIDTH_DEF = 32;

  localparam int BYTE_W     = 8;
  localparam int OPCODE_W   = 4;
  localparam int LEN7_W     = 7;
  localparam int HDR_W      = 4;
  localparam int PAYLOAD_W  = 64;
  localparam int KEY_W      = 32;
  localparam int FRAME_W    = 32;

  // bit positions in the first two header bytes
  localparam int FIN_BIT  = 7;
  localparam int MASK_BIT = 7;

  // 7-bit length escape codes
  localparam logic [LEN7_W-1:0] LEN_EXT16 = 7'd126;
  localparam logic [LEN7_W-1:0] LEN_EXT64 = 7'd127;

  // header byte counts
  localparam logic [HDR_W-1:0] BASE_HDR    = 4'd2;
  localparam logic [HDR_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [HDR_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [HDR_W-1:0] KEY_BYTES   = 4'd4;
  localparam logic [HDR_W-1:0] FIRST_COUNT = 4'd1;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SECOND,
    PH_REST
  } phase_t;

endpackage

@@ rtl/wsfhp_in_if.sv @@
interface wsfhp_in_if import wsfhp_pkg::*; #(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  start_req;
  logic [BYTE_W-1:0]     data_byte;
  logic [SIZE_WIDTH-1:0] buf_size;

  modport source (output valid, start_req, data_byte, buf_size, input ready);
  modport sink (input valid, start_req, data_byte, buf_size, output ready);
endinterface

@@ rtl/wsfhp_out_if.sv @@
interface wsfhp_out_if import wsfhp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic                 fin;
  logic [OPCODE_W-1:0]  frame_opcode;
  logic                 masked;
  logic [PAYLOAD_W-1:0] payload_len;
  logic [KEY_W-1:0]     mask_key;
  logic [HDR_W-1:0]     header_length;
  logic [FRAME_W-1:0]   frame_length;

  modport source (
    output valid, status, fin, frame_opcode, masked, payload_len, mask_key,
           header_length, frame_length,
    input  ready
  );
  modport sink (
    input  valid, status, fin, frame_opcode, masked, payload_len, mask_key,
           header_length, frame_length,
    output ready
  );
endinterface

@@ rtl/wsfhp_in_reg.sv @@
module wsfhp_in_reg import wsfhp_pkg::*; #(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  wsfhp_in_if.sink   up,
  wsfhp_in_if.source down
);

  logic                  valid;
  logic                  start_req;
  logic [BYTE_W-1:0]     data_byte;
  logic [SIZE_WIDTH-1:0] buf_size;

  // refill in the same cycle the held item moves on
  assign up.ready = !valid || down.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up.ready) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      start_req <= up.start_req;
      data_byte <= up.data_byte;
      buf_size  <= up.buf_size;
    end
  end

  assign down.valid     = valid;
  assign down.start_req = start_req;
  assign down.data_byte = data_byte;
  assign down.buf_size  = buf_size;

endmodule

@@ rtl/wsfhp_parser.sv @@
module wsfhp_parser import wsfhp_pkg::*; #(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wsfhp_in_if.sink    item,
  wsfhp_out_if.source result
);

  phase_t                phase, phase_next;
  logic [HDR_W-1:0]      byte_count, byte_count_next;
  logic [HDR_W-1:0]      len_end, len_end_next;
  logic [HDR_W-1:0]      needed_header, needed_header_next;
  logic [PAYLOAD_W-1:0]  acc, acc_next;
  logic [KEY_W-1:0]      key, key_next;
  logic                  fin, fin_next;
  logic [OPCODE_W-1:0]   opcode, opcode_next;
  logic                  masked, masked_next;
  logic [SIZE_WIDTH-1:0] latched_size, latched_size_next;
  logic [SIZE_WIDTH-1:0] room, room_next;

  logic                  take;
  logic [LEN7_W-1:0]     len7;
  logic [HDR_W-1:0]      ext_bytes;
  logic                  start_short;
  logic                  second_short;
  logic                  rest_last;
  logic                  too_long;

  logic                  res_valid;
  logic                  res_short;

  // an item is consumed whenever the result register can take a result
  assign take       = item.valid && item.ready;
  assign item.ready = result.ready;

  // shared decode of the current byte
  always_comb begin
    len7 = item.data_byte[LEN7_W-1:0];
    if (len7 == LEN_EXT16) begin
      ext_bytes = EXT16_BYTES;
    end else if (len7 == LEN_EXT64) begin
      ext_bytes = EXT64_BYTES;
    end else begin
      ext_bytes = '0;
    end
    start_short  = item.buf_size < SIZE_WIDTH'(BASE_HDR);
    second_short = latched_size < SIZE_WIDTH'(needed_header_next);
    rest_last    = byte_count_next >= needed_header;
  end

  // next state
  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    len_end_next       = len_end;
    needed_header_next = needed_header;
    acc_next           = acc;
    key_next           = key;
    fin_next           = fin;
    opcode_next        = opcode;
    masked_next        = masked;
    latched_size_next  = latched_size;
    room_next          = room;
    if (item.start_req) begin
      latched_size_next  = item.buf_size;
      acc_next           = '0;
      key_next           = '0;
      needed_header_next = BASE_HDR;
      byte_count_next    = FIRST_COUNT;
      fin_next           = item.data_byte[FIN_BIT];
      opcode_next        = item.data_byte[OPCODE_W-1:0];
      masked_next        = 1'b0;
      phase_next         = start_short ? PH_IDLE : PH_SECOND;
    end else begin
      unique case (phase)
        PH_SECOND: begin
          masked_next        = item.data_byte[MASK_BIT];
          len_end_next       = BASE_HDR + ext_bytes;
          needed_header_next = BASE_HDR + ext_bytes
                               + (item.data_byte[MASK_BIT] ? KEY_BYTES : '0);
          acc_next           = (ext_bytes != '0) ? '0 : PAYLOAD_W'(len7);
          byte_count_next    = BASE_HDR;
          room_next          = latched_size - SIZE_WIDTH'(needed_header_next);
          phase_next         = (second_short || needed_header_next == BASE_HDR)
                               ? PH_IDLE : PH_REST;
        end
        PH_REST: begin
          if (byte_count < len_end) begin
            acc_next = {acc[PAYLOAD_W-BYTE_W-1:0], item.data_byte};
          end else begin
            key_next = {key[KEY_W-BYTE_W-1:0], item.data_byte};
          end
          byte_count_next = byte_count + HDR_W'(1);
          phase_next      = rest_last ? PH_IDLE : PH_REST;
        end
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res_short = 1'b0;
    too_long  = acc_next > PAYLOAD_W'(room_next);
    if (item.start_req) begin
      res_valid = start_short;
      res_short = 1'b1;
    end else begin
      unique case (phase)
        PH_SECOND: begin
          res_valid = second_short || needed_header_next == BASE_HDR;
          res_short = second_short || too_long;
        end
        PH_REST: begin
          res_valid = rest_last;
          res_short = too_long;
        end
        PH_IDLE: begin
          res_valid = 1'b0;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  assign result.valid         = item.valid && res_valid;
  assign result.status        = res_short ? STATUS_SHORT : STATUS_OK;
  assign result.fin           = !res_short && fin_next;
  assign result.frame_opcode  = res_short ? '0 : opcode_next;
  assign result.masked        = !res_short && masked_next;
  assign result.payload_len   = res_short ? '0 : acc_next;
  assign result.mask_key      = (res_short || !masked_next) ? '0 : key_next;
  assign result.header_length = res_short ? '0 : needed_header_next;
  assign result.frame_length  = res_short ? '0
                                : acc_next[FRAME_W-1:0] + FRAME_W'(needed_header_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_count    <= '0;
      needed_header <= '0;
      len_end       <= '0;
    end else if (take) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      needed_header <= needed_header_next;
      len_end       <= len_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      key          <= '0;
      fin          <= 1'b0;
      opcode       <= '0;
      masked       <= 1'b0;
      latched_size <= '0;
      room         <= '0;
    end else if (take) begin
      acc          <= acc_next;
      key          <= key_next;
      fin          <= fin_next;
      opcode       <= opcode_next;
      masked       <= masked_next;
      latched_size <= latched_size_next;
      room         <= room_next;
    end
  end

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STATUS_SHORT) |->
      (result.payload_len == '0 && result.header_length == '0 &&
       result.frame_length == '0 && result.mask_key == '0))
    else $error("short buffer result carries nonzero fields");

  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STATUS_OK) |->
      (result.header_length >= BASE_HDR && result.header_length <= 4'd14))
    else $error("header length out of range");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (take && result.valid) |=> (phase == PH_IDLE))
    else $error("parser not idle after a result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_REST) |-> (byte_count < needed_header && byte_count >= BASE_HDR))
    else $error("header byte count out of bounds");

endmodule

@@ rtl/wsfhp_out_reg.sv @@
module wsfhp_out_reg import wsfhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  wsfhp_out_if.sink   up,
  wsfhp_out_if.source down
);

  logic                 valid;
  logic                 status;
  logic                 fin;
  logic [OPCODE_W-1:0]  frame_opcode;
  logic                 masked;
  logic [PAYLOAD_W-1:0] payload_len;
  logic [KEY_W-1:0]     mask_key;
  logic [HDR_W-1:0]     header_length;
  logic [FRAME_W-1:0]   frame_length;

  assign up.ready = !valid || down.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up.ready) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      status        <= up.status;
      fin           <= up.fin;
      frame_opcode  <= up.frame_opcode;
      masked        <= up.masked;
      payload_len   <= up.payload_len;
      mask_key      <= up.mask_key;
      header_length <= up.header_length;
      frame_length  <= up.frame_length;
    end
  end

  assign down.valid         = valid;
  assign down.status        = status;
  assign down.fin           = fin;
  assign down.frame_opcode  = frame_opcode;
  assign down.masked        = masked;
  assign down.payload_len   = payload_len;
  assign down.mask_key      = mask_key;
  assign down.header_length = header_length;
  assign down.frame_length  = frame_length;

endmodule

@@ rtl/websocket_frame_header_parser.sv @@
// websocket frame header parser: takes one buffer byte per item on stream and
// returns at most one header item per buffer on header. an item with
// start_req set is byte 0 of a new buffer and samples the buffer size; it also
// abandons any header still in progress. fin, opcode, mask bit, the 7/16/64-bit
// payload length (extended forms big-endian) and the optional 4-byte masking
// key are gathered, and one item goes out when the header is complete. status
// is 1 when the buffer is too short, reported as early as it is known: on the
// start byte for sizes below 2, on the second byte when the header itself
// does not fit, else on the last header byte when header plus payload does
// not fit; all other fields are 0 then. bytes after the header are dropped
// until the next start. throughput is one byte per cycle: an input register
// feeds a single pass of parser logic that writes a result register, so a byte
// reaches header through both registers, and stream stalls only while the
// result register holds an item that header has not taken.
module websocket_frame_header_parser import wsfhp_pkg::*; #(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wsfhp_in_if.sink    stream,
  wsfhp_out_if.source header
);

  // byte after the input register
  wsfhp_in_if #(.SIZE_WIDTH(SIZE_WIDTH)) staged ();

  // result before the output register
  wsfhp_out_if parsed ();

  wsfhp_in_reg #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_in_reg (
    .clk  (clk),
    .rst  (rst),
    .up   (stream),
    .down (staged)
  );

  // header state machine and frame size checks
  wsfhp_parser #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .item   (staged),
    .result (parsed)
  );

  // holds a finished header item until it is taken
  wsfhp_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .up   (parsed),
    .down (header)
  );

endmodule
